// ----- rtl/core/button_debounce_press_classifier_macros.svh -----
// Assertion macros for the checker file of the button classifier.
// Depends on nothing; the clock aclk and reset aresetn must be in scope.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bdpc_pkg.sv -----
// Package for the button debounce and press classifier: constants, codes, types.
// No dependencies.
`timescale 1ns / 1ps

package bdpc_pkg;

    // Default sizes
    localparam int BUTTON_COUNT_DEF = 4;
    localparam int TIME_BITS_DEF    = 32;

    // Fixed field widths
    localparam int LEVEL_W   = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ID_W      = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_OFF  = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] POWER_OFF_RST  = 16'd3000;

    // Button roles
    localparam int TALK_BUTTON  = 0;
    localparam int POWER_BUTTON = 1;

    typedef enum logic [1:0] {
        EVT_PRESSED  = 2'd0,
        EVT_RELEASED = 2'd1,
        EVT_SHORT    = 2'd2,
        EVT_LONG     = 2'd3
    } evt_kind_t;

    // What one lane found on the current tick
    typedef struct packed {
        logic      hit;
        evt_kind_t kind;
        logic      held;
    } lane_evt_t;

endpackage

// ----- rtl/core/bdpc_lane.sv -----
// One button lane: debounce, accepted level, hold timing and event decision.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps

module bdpc_lane #(
    parameter int TIME_BITS = bdpc_pkg::TIME_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic                        talk_mode,
    input  logic                        sample,
    input  logic [TIME_BITS-1:0]        now,
    input  logic [bdpc_pkg::CFG_W-1:0]  debounce,
    input  logic [bdpc_pkg::CFG_W-1:0]  hold_need,
    output bdpc_pkg::lane_evt_t         evt
);

    logic                 prev_reg, prev_next;
    logic [TIME_BITS-1:0] settle_reg, settle_next;
    logic                 held_reg, held_next;
    logic [TIME_BITS-1:0] hold_reg, hold_next;
    logic                 lr_reg, lr_next;

    logic                 settled;
    logic                 press_new;
    logic [TIME_BITS-1:0] hold_base;
    logic [TIME_BITS-1:0] hold_elapsed;
    logic                 lr_eff;

    // Settle timing: a change restarts the window
    assign prev_next   = sample;
    assign settle_next = (sample != prev_reg) ? now : settle_reg;
    assign settled     = (now - settle_next) >= TIME_BITS'(debounce);

    // Hold timing, with a press accepted on this tick starting now
    assign press_new    = sample && !held_reg;
    assign hold_base    = press_new ? now : hold_reg;
    assign hold_elapsed = now - hold_base;
    assign lr_eff       = press_new ? 1'b0 : lr_reg;

    // Event decision
    always_comb begin
        held_next = held_reg;
        hold_next = hold_reg;
        lr_next   = lr_reg;
        evt.hit   = 1'b0;
        evt.kind  = bdpc_pkg::EVT_PRESSED;
        if (settled) begin
            if (talk_mode) begin
                if (sample != held_reg) begin
                    held_next = sample;
                    evt.hit   = 1'b1;
                    evt.kind  = sample ? bdpc_pkg::EVT_PRESSED : bdpc_pkg::EVT_RELEASED;
                end
            end else begin
                if (press_new) begin
                    held_next = 1'b1;
                    hold_next = now;
                    lr_next   = 1'b0;
                end
                if (sample && !lr_eff && (hold_elapsed >= TIME_BITS'(hold_need))) begin
                    lr_next  = 1'b1;
                    evt.hit  = 1'b1;
                    evt.kind = bdpc_pkg::EVT_LONG;
                end
                if (!sample && held_reg) begin
                    held_next = 1'b0;
                    if (!lr_reg) begin
                        evt.hit  = 1'b1;
                        evt.kind = bdpc_pkg::EVT_SHORT;
                    end
                end
            end
        end
        evt.held = held_next;
    end

    // Lane state, updated once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= 1'b0;
            settle_reg <= '0;
            held_reg   <= 1'b0;
            hold_reg   <= '0;
            lr_reg     <= 1'b0;
        end else if (step) begin
            prev_reg   <= prev_next;
            settle_reg <= settle_next;
            held_reg   <= held_next;
            hold_reg   <= hold_next;
            lr_reg     <= lr_next;
        end
    end

endmodule

// ----- rtl/core/bdpc_merge.sv -----
// Merging stage: registers the lane events of one tick and drains them in
// button order, one per cycle while m_ready is high. Depends on bdpc_pkg.
`timescale 1ns / 1ps

module bdpc_merge #(
    parameter int BUTTON_COUNT = bdpc_pkg::BUTTON_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  bdpc_pkg::lane_evt_t         evt [BUTTON_COUNT],
    input  logic                        talk_in,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic [bdpc_pkg::ID_W-1:0]   m_button_id,
    output logic [1:0]                  m_event_kind,
    output logic                        m_talk_held,
    output logic                        m_last_event,
    output logic                        load_ok
);

    localparam int IDX_W = $clog2(BUTTON_COUNT);

    logic [BUTTON_COUNT-1:0] pend_reg, pend_next;
    bdpc_pkg::evt_kind_t     kind_reg [BUTTON_COUNT];
    logic                    talk_reg;

    logic [IDX_W-1:0]        sel;
    logic                    only_one;
    logic                    drain;
    logic [BUTTON_COUNT-1:0] hits;

    // Lowest pending button goes first
    always_comb begin
        sel = '0;
        for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            hits[i] = evt[i].hit;
        end
    end

    assign only_one = (pend_reg & (pend_reg - 1'b1)) == '0;
    assign m_valid  = pend_reg != '0;
    assign drain    = m_valid && m_ready;
    assign load_ok  = !m_valid || (m_ready && only_one);

    assign m_button_id  = bdpc_pkg::ID_W'(sel);
    assign m_event_kind = kind_reg[sel];
    assign m_talk_held  = talk_reg;
    assign m_last_event = only_one;

    // Pending set: reload from the lanes or retire the shown event
    always_comb begin
        pend_next = pend_reg;
        if (load) begin
            pend_next = hits;
        end else if (drain) begin
            pend_next = pend_reg & ~(BUTTON_COUNT'(1) << sel);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // Event payload, captured with the tick
    always_ff @(posedge aclk) begin
        if (load) begin
            talk_reg <= talk_in;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                kind_reg[i] <= evt[i].kind;
            end
        end
    end

endmodule

// ----- rtl/core/button_debounce_press_classifier.sv -----
// Top level of the button debounce and press classifier: tick counter,
// configuration registers, button lanes and merging stage. Depends on bdpc_pkg.
//
//   channel  | signals                                   | role
//   s_       | s_valid s_ready s_pressed_levels          | one tick, button levels
//   m_       | m_valid m_ready m_button_id m_event_kind  | one event per transaction
//            | m_talk_held m_last_event                  |
//   cfg_     | cfg_we cfg_index cfg_wdata                | register write, no wait
//
// Each tick is evaluated by all lanes in the cycle it is accepted; its events
// (0 to 4) are then shown one per cycle while m_ready is high, through the
// single output port. The next tick is accepted in the cycle the
// last event drains. Reset is synchronous; there is no clearing pass.
// A stalled m_ready holds the event and, on the last event, the input too.
`timescale 1ns / 1ps

module button_debounce_press_classifier #(
    parameter int BUTTON_COUNT = bdpc_pkg::BUTTON_COUNT_DEF,
    parameter int TIME_BITS    = bdpc_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bdpc_pkg::LEVEL_W-1:0]    s_pressed_levels,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bdpc_pkg::ID_W-1:0]       m_button_id,
    output logic [1:0]                      m_event_kind,
    output logic                            m_talk_held,
    output logic                            m_last_event,
    input  logic                            cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdpc_pkg::CFG_W-1:0]      cfg_wdata
);

    logic [TIME_BITS-1:0]       tick_reg;
    logic [bdpc_pkg::CFG_W-1:0] debounce_reg;
    logic [bdpc_pkg::CFG_W-1:0] long_press_reg;
    logic [bdpc_pkg::CFG_W-1:0] power_off_reg;

    logic                 accept;
    bdpc_pkg::lane_evt_t  lane_evt [BUTTON_COUNT];

    assign accept = s_valid && s_ready;

    // Free-running tick time, one step per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
        end else if (accept) begin
            tick_reg <= tick_reg + 1'b1;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= bdpc_pkg::DEBOUNCE_RST;
            long_press_reg <= bdpc_pkg::LONG_PRESS_RST;
            power_off_reg  <= bdpc_pkg::POWER_OFF_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bdpc_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                bdpc_pkg::REG_LONG_PRESS: long_press_reg <= cfg_wdata;
                bdpc_pkg::REG_POWER_OFF:  power_off_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // One lane per button; buttons past the input field read released
    for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
        logic                       sample;
        logic [bdpc_pkg::CFG_W-1:0] need;

        if (i < bdpc_pkg::LEVEL_W) begin : g_pin
            assign sample = s_pressed_levels[i];
        end else begin : g_nopin
            assign sample = 1'b0;
        end

        assign need = (i == bdpc_pkg::POWER_BUTTON) ? power_off_reg : long_press_reg;

        bdpc_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (accept),
            .talk_mode (i == bdpc_pkg::TALK_BUTTON),
            .sample    (sample),
            .now       (tick_reg),
            .debounce  (debounce_reg),
            .hold_need (need),
            .evt       (lane_evt[i])
        );
    end

    // Merge lane events into the result stream
    bdpc_merge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept),
        .evt          (lane_evt),
        .talk_in      (lane_evt[bdpc_pkg::TALK_BUTTON].held),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_button_id  (m_button_id),
        .m_event_kind (m_event_kind),
        .m_talk_held  (m_talk_held),
        .m_last_event (m_last_event),
        .load_ok      (s_ready)
    );

endmodule

// ----- rtl/core/bdpc_checker.sv -----
// Port-level checker for the button classifier, bound to the top level.
// Depends on bdpc_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "button_debounce_press_classifier_macros.svh"

module bdpc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bdpc_pkg::ID_W-1:0]     m_button_id,
    input logic [1:0]                    m_event_kind,
    input logic                          m_talk_held,
    input logic                          m_last_event
);

    // Held result keeps its payload
    `BDPC_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_button_id) && $stable(m_event_kind) && $stable(m_talk_held) && $stable(m_last_event), "result changed while stalled")

    // Input only stalls behind pending results
    `BDPC_ASSERT_NOW(a_stall, !s_ready, m_valid, "input stalled with no result pending")

    // Push-to-talk gives only pressed and released
    `BDPC_ASSERT_NOW(a_talk_kind, m_valid && (m_button_id == bdpc_pkg::ID_W'(bdpc_pkg::TALK_BUTTON)), (m_event_kind == bdpc_pkg::EVT_PRESSED) || (m_event_kind == bdpc_pkg::EVT_RELEASED), "push-to-talk gave a press classification")

    // Talk flag follows the push-to-talk event
    `BDPC_ASSERT_NOW(a_talk_flag, m_valid && (m_button_id == bdpc_pkg::ID_W'(bdpc_pkg::TALK_BUTTON)), m_talk_held == (m_event_kind == bdpc_pkg::EVT_PRESSED), "talk flag disagrees with push-to-talk event")

    // A transaction that is not the last of its tick is followed by another
    `BDPC_ASSERT_NEXT(a_more, m_valid && m_ready && !m_last_event, m_valid, "tick events cut short")

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (.*);

// ----- test/button_debounce_press_classifier_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the button debounce and press classifier.
// Sends tick transactions, predicts button events locally and checks the m_ channel.
// Depends on bdpc_pkg and button_debounce_press_classifier.

module button_debounce_press_classifier_tb;
    import bdpc_pkg::*;

    localparam int                   NUM_BUTTONS   = BUTTON_COUNT_DEF;
    localparam int                   TIME_W        = TIME_BITS_DEF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;
    localparam int                   SETTLE_CYCLES = 4;
    localparam int                   RUN_CAP       = 40;

    // One expected event on the m_ channel
    typedef struct {
        logic [ID_W-1:0] button;
        evt_kind_t       kind;
        logic            talk;
        logic            last;
    } button_evt_t;

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [LEVEL_W-1:0]   s_pressed_levels = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic [ID_W-1:0]      m_button_id;
    logic [1:0]           m_event_kind;
    logic                 m_talk_held;
    logic                 m_last_event;
    logic                 cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index        = '0;
    logic [CFG_W-1:0]     cfg_wdata        = '0;

    int mismatches         = 0;
    int sender_idle_pct    = 0;
    int receiver_idle_pct  = 0;

    button_evt_t tick_events [$];

    // Predictor state: registers and per-button debounce/hold tracking
    logic [CFG_W-1:0]                   pred_debounce   = DEBOUNCE_RST;
    logic [CFG_W-1:0]                   pred_long_press = LONG_PRESS_RST;
    logic [CFG_W-1:0]                   pred_power_off  = POWER_OFF_RST;
    logic [TIME_W-1:0]                  pred_now        = '0;
    logic [NUM_BUTTONS-1:0]             pred_sample     = '0;
    logic [NUM_BUTTONS-1:0]             pred_held       = '0;
    logic [NUM_BUTTONS-1:0]             pred_long_done  = '0;
    logic [NUM_BUTTONS-1:0][TIME_W-1:0] pred_settle     = '0;
    logic [NUM_BUTTONS-1:0][TIME_W-1:0] pred_hold       = '0;
    logic                               pred_talk       = 1'b0;

    // Random level generator: current level and ticks left per button
    logic [NUM_BUTTONS-1:0] gen_level = '0;
    int                     gen_left [NUM_BUTTONS];

    button_debounce_press_classifier dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pressed_levels (s_pressed_levels),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_button_id      (m_button_id),
        .m_event_kind     (m_event_kind),
        .m_talk_held      (m_talk_held),
        .m_last_event     (m_last_event),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic button_evt_t make_event(input int b, input evt_kind_t k);
        button_evt_t e;
        e.button = ID_W'(b);
        e.kind   = k;
        e.talk   = pred_talk;
        e.last   = 1'b0;
        return e;
    endfunction

    // Debounce every button, classify, queue this tick's events in button order
    function automatic void predict_tick(input logic [LEVEL_W-1:0] levels);
        button_evt_t       evts [NUM_BUTTONS];
        int                n;
        logic              smp;
        logic [TIME_W-1:0] diff;
        logic [CFG_W-1:0]  need;
        n = 0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            smp = levels[b];
            if (smp != pred_sample[b])
                pred_settle[b] = pred_now;
            pred_sample[b] = smp;
            diff = pred_now - pred_settle[b];
            if (diff < pred_debounce)
                continue;
            if (b == TALK_BUTTON) begin
                if (smp != pred_held[b]) begin
                    pred_held[b] = smp;
                    pred_talk    = smp;
                    evts[n] = make_event(b, smp ? EVT_PRESSED : EVT_RELEASED);
                    n++;
                end
                continue;
            end
            if (smp && !pred_held[b]) begin
                pred_held[b]      = 1'b1;
                pred_hold[b]      = pred_now;
                pred_long_done[b] = 1'b0;
            end
            if (smp && pred_held[b] && !pred_long_done[b]) begin
                need = (b == POWER_BUTTON) ? pred_power_off : pred_long_press;
                diff = pred_now - pred_hold[b];
                if (diff >= need) begin
                    pred_long_done[b] = 1'b1;
                    evts[n] = make_event(b, EVT_LONG);
                    n++;
                end
            end
            if (!smp && pred_held[b]) begin
                pred_held[b] = 1'b0;
                if (!pred_long_done[b]) begin
                    evts[n] = make_event(b, EVT_SHORT);
                    n++;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            evts[k].last = (k == n - 1);
            tick_events.push_back(evts[k]);
        end
        pred_now = pred_now + 1'b1;
    endfunction

    // Predict on accepted ticks first, then check the accepted event
    always @(posedge aclk) begin : event_monitor
        button_evt_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_tick(s_pressed_levels);
            if (m_valid && m_ready) begin
                if (tick_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event: button %0d kind %0d",
                                              m_button_id, m_event_kind));
                end else begin
                    want = tick_events.pop_front();
                    if (m_button_id !== want.button)
                        report_mismatch($sformatf("button_id %0d, want %0d",
                                                  m_button_id, want.button));
                    if (m_event_kind !== want.kind)
                        report_mismatch($sformatf("event_kind %0d, want %0d (button %0d)",
                                                  m_event_kind, want.kind, want.button));
                    if (m_talk_held !== want.talk)
                        report_mismatch($sformatf("talk_held %0b, want %0b (button %0d)",
                                                  m_talk_held, want.talk, want.button));
                    if (m_last_event !== want.last)
                        report_mismatch($sformatf("last_event %0b, want %0b (button %0d)",
                                                  m_last_event, want.last, want.button));
                end
            end
        end
    end

    // Receiver stalls
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);

    task automatic set_idle(input int sender_pct, input int receiver_pct);
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
    endtask

    // Valid stays high across back-to-back ticks; it only drops for a gap
    task automatic send_tick(input logic [LEVEL_W-1:0] levels);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid          <= 1'b1;
        s_pressed_levels <= levels;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending, wait for all events, then let the block settle
    task automatic drain_events();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tick_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_DEBOUNCE:   pred_debounce   = value;
            REG_LONG_PRESS: pred_long_press = value;
            REG_POWER_OFF:  pred_power_off  = value;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                              input logic [CFG_W-1:0] pwr);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG_PRESS, lng);
        write_reg(REG_POWER_OFF, pwr);
        cfg_we <= 1'b0;
    endtask

    // Run length: a bounce shorter than the debounce, a short press, or a long press
    function automatic int pick_run(input int b);
        int deb;
        int hold;
        int r;
        deb  = (pred_debounce > RUN_CAP) ? RUN_CAP : int'(pred_debounce);
        hold = (b == POWER_BUTTON) ? int'(pred_power_off) : int'(pred_long_press);
        if (hold > RUN_CAP)
            hold = RUN_CAP;
        r = $urandom_range(99);
        if (r < 20)
            return $urandom_range((deb > 1) ? deb : 1, 1);
        if (r < 65)
            return deb + $urandom_range((hold > 1) ? hold : 1, 1);
        return deb + hold + $urandom_range(8, 1);
    endfunction

    // Mostly well-formed press/release runs, some single-tick noise
    task automatic random_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                                input logic [CFG_W-1:0] pwr, input int count);
        set_timing(deb, lng, pwr);
        for (int k = 0; k < count; k++) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (gen_left[b] == 0) begin
                    gen_level[b] = ~gen_level[b];
                    gen_left[b]  = pick_run(b);
                end
                gen_left[b]--;
            end
            if ($urandom_range(99) < 8)
                send_tick(LEVEL_W'($urandom_range(15)));
            else
                send_tick(gen_level);
        end
        drain_events();
    endtask

    // Reset timing: nothing settles within a few ticks
    task automatic test_reset_values();
        send_tick(4'hF);
        send_tick(4'hF);
        send_tick(4'hA);
        drain_events();
    endtask

    // Zero debounce and hold: press and long press on the same tick, four events at once
    task automatic test_zero_timing();
        set_timing('0, '0, '0);
        send_tick(4'hF);
        send_tick(4'h0);
        send_tick(4'h0);
        send_tick(4'h5);
        drain_events();
    endtask

    // Short presses on release, then long presses with distinct hold times
    task automatic test_short_and_long();
        set_timing(16'd1, 16'd2, 16'd3);
        send_tick(4'h6);
        send_tick(4'h6);
        send_tick(4'h0);
        send_tick(4'h0);
        repeat (5) send_tick(4'hF);
        send_tick(4'h0);
        send_tick(4'h0);
        drain_events();
    endtask

    // A write to the spare index must not alias onto the debounce register
    task automatic test_unused_index();
        write_reg(REG_UNUSED, '0);
        cfg_we <= 1'b0;
        send_tick(4'h1);
        send_tick(4'h1);
        send_tick(4'h0);
        send_tick(4'h0);
        drain_events();
    endtask

    task automatic test_random_slow_sink();
        set_idle(36, 51);
        random_phase(16'd3, 16'd8, 16'd12, 100);
        random_phase(16'd0, 16'hFFFF, 16'hFFFF, 40);
    endtask

    task automatic test_random_slow_source();
        set_idle(51, 36);
        random_phase(16'd1, 16'd2, 16'd4, 100);
        random_phase(16'hFFFF, 16'd1, 16'd1, 20);
        random_phase(16'd5, 16'd20, 16'd40, 30);
    endtask

    task automatic test_random_full_rate();
        set_idle(0, 0);
        random_phase(16'd0, 16'd1, 16'd1, 70);
        random_phase(16'd4, 16'd10, 16'd16, 70);
    endtask

    initial begin
        for (int b = 0; b < NUM_BUTTONS; b++)
            gen_left[b] = 0;
        set_idle(36, 51);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_zero_timing();
        test_short_and_long();
        test_unused_index();
        test_random_slow_sink();
        test_random_slow_source();
        test_random_full_rate();

        if (tick_events.size() != 0)
            report_mismatch($sformatf("%0d expected events never arrived", tick_events.size()));
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
